### rtl/signed_reciprocal_power_macros.svh
// Assertion macros shared by the signed_reciprocal_power RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef SIGNED_RECIPROCAL_POWER_MACROS_SVH
`define SIGNED_RECIPROCAL_POWER_MACROS_SVH

// same-cycle implication
`define SRP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define SRP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

### rtl/srp_pkg.sv
// Package for signed_reciprocal_power: constants, sideband type, root table.
// No dependencies.
`timescale 1ns / 1ps
package srp_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int LOG_BITS      = 24;
	localparam int W_W           = 16;
	localparam int AW_W          = 17;

	// flags and |w| that ride alongside each request
	typedef struct packed {
		logic            zero;
		logic            one;
		logic            neg;
		logic [AW_W-1:0] aw;
	} srp_side_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] b;
		rem = v;
		res = '0;
		b   = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (rem >= res + b) begin
				rem = rem - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// Q0.30 approximation of 2^(-2^-k)
	function automatic logic [29:0] root_tab(input int k);
		logic [63:0] t;
		t = 64'd1 << 29;
		for (int i = 1; i <= k; i++)
			t = isqrt64(t << 30);
		return t[29:0];
	endfunction
endpackage

### rtl/srp_if.sv
// Request and result channel interfaces for signed_reciprocal_power.
// Widths follow the fraction width parameter; no package use.
`timescale 1ns / 1ps
interface srp_in_if #(parameter int FRAC_BITS = 16) ();
	logic                valid;
	logic                ready;
	logic [FRAC_BITS:0]  x_value;
	logic signed [15:0]  weight;
	modport source(output valid, x_value, weight, input ready);
	modport sink(input valid, x_value, weight, output ready);
endinterface

interface srp_out_if #(parameter int FRAC_BITS = 16) ();
	logic                       valid;
	logic                       ready;
	logic signed [FRAC_BITS+1:0] result;
	modport source(output valid, result, input ready);
	modport sink(input valid, result, output ready);
endinterface

### rtl/srp_log2.sv
// -log2 front end: normalise, then one squaring per stage for each log bit.
// Depends on srp_pkg.
`timescale 1ns / 1ps
module srp_log2 import srp_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              v_in,
	input  logic [FRAC_BITS-1:0]              x,
	input  srp_side_t                         side_in,
	output logic                              v_out,
	output logic [$clog2(FRAC_BITS+1)-1:0]    e,
	output logic [LOG_BITS-1:0]               frac,
	output srp_side_t                         side_out
);
	localparam int EW = $clog2(FRAC_BITS+1);
	localparam int PW = $clog2(FRAC_BITS);

	logic [30:0]         m_s    [0:LOG_BITS];
	logic [LOG_BITS-1:0] frac_s [0:LOG_BITS];
	logic [EW-1:0]       e_s    [0:LOG_BITS];
	srp_side_t           side_s [0:LOG_BITS];
	logic                v_s    [0:LOG_BITS];

	logic [PW-1:0] p;
	always_comb begin
		p = '0;
		for (int k = 0; k < FRAC_BITS; k++)
			if (x[k]) p = PW'(k);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0]    <= 31'(x) << (6'd30 - 6'(p));
			frac_s[0] <= '0;
			e_s[0]    <= EW'(FRAC_BITS) - EW'(p);
			side_s[0] <= side_in;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s[0] <= 1'b0;
		else if (en) v_s[0] <= v_in;
	end

	for (genvar k = 0; k < LOG_BITS; k++) begin : g_sq
		logic [61:0] sq;
		logic [31:0] t;
		assign sq = 62'(m_s[k]) * 62'(m_s[k]);
		assign t  = sq[61:30];
		always_ff @(posedge clk) begin
			if (en) begin
				m_s[k+1]    <= t[31] ? t[31:1] : t[30:0];
				frac_s[k+1] <= {frac_s[k][LOG_BITS-2:0], t[31]};
				e_s[k+1]    <= e_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k+1] <= 1'b0;
			else if (en) v_s[k+1] <= v_s[k];
		end
	end

	assign v_out    = v_s[LOG_BITS];
	assign e        = e_s[LOG_BITS];
	assign frac     = frac_s[LOG_BITS];
	assign side_out = side_s[LOG_BITS];
endmodule

### rtl/srp_exp2.sv
// exp2 back end: one conditional root multiply per stage, shift, round, sign.
// Depends on srp_pkg; the last stage is the output register.
`timescale 1ns / 1ps
module srp_exp2 import srp_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int NW        = 37
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        v_in,
	input  logic [NW-1:0]               q,
	input  srp_side_t                   side_in,
	output logic                        v_out,
	output logic signed [FRAC_BITS+1:0] result
);
	localparam int NB = NW - LOG_BITS;
	localparam logic [FRAC_BITS+1:0] ONE_M = (FRAC_BITS+2)'(1) << FRAC_BITS;

	logic [30:0]         r_s    [0:LOG_BITS];
	logic [LOG_BITS-1:0] f_s    [0:LOG_BITS];
	logic [NB-1:0]       n_s    [0:LOG_BITS];
	srp_side_t           side_s [0:LOG_BITS+1];
	logic                v_s    [0:LOG_BITS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0]    <= {1'b1, 30'b0};
			f_s[0]    <= q[LOG_BITS-1:0];
			n_s[0]    <= q[NW-1:LOG_BITS];
			side_s[0] <= side_in;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s[0] <= 1'b0;
		else if (en) v_s[0] <= v_in;
	end

	for (genvar k = 1; k <= LOG_BITS; k++) begin : g_mul
		localparam logic [29:0] TK = root_tab(k);
		logic [60:0] prod;
		assign prod = 61'(r_s[k-1]) * 61'(TK);
		always_ff @(posedge clk) begin
			if (en) begin
				r_s[k]    <= f_s[k-1][LOG_BITS-k] ? prod[60:30] : r_s[k-1];
				f_s[k]    <= f_s[k-1];
				n_s[k]    <= n_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k] <= 1'b0;
			else if (en) v_s[k] <= v_s[k-1];
		end
	end

	// integer part of the exponent
	logic [30:0] sh_s;
	always_ff @(posedge clk) begin
		if (en) begin
			sh_s <= (n_s[LOG_BITS] >= NB'(31)) ? '0 : r_s[LOG_BITS] >> n_s[LOG_BITS][4:0];
			side_s[LOG_BITS+1] <= side_s[LOG_BITS];
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s[LOG_BITS+1] <= 1'b0;
		else if (en) v_s[LOG_BITS+1] <= v_s[LOG_BITS];
	end

	logic [31:0]          rnd;
	logic [FRAC_BITS+1:0] rr;
	logic [FRAC_BITS+1:0] mag;
	srp_side_t            sd;
	always_comb begin
		sd  = side_s[LOG_BITS+1];
		rnd = {1'b0, sh_s} + (32'd1 << (29 - FRAC_BITS));
		rr  = rnd[31:30-FRAC_BITS];
		if (sd.zero)           mag = '0;
		else if (sd.one)       mag = ONE_M;
		else if (rr > ONE_M)   mag = ONE_M;
		else                   mag = rr;
	end

	logic signed [FRAC_BITS+1:0] result_s;
	logic                        vo_s;
	always_ff @(posedge clk) begin
		if (en) result_s <= sd.neg ? -$signed(mag) : $signed(mag);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vo_s <= 1'b0;
		else if (en) vo_s <= v_s[LOG_BITS+1];
	end

	assign v_out  = vo_s;
	assign result = result_s;
endmodule

### rtl/signed_reciprocal_power.sv
// signed_reciprocal_power: streaming signed fractional power.
// Request channel operand (srp_in_if): x_value, unsigned Q1.FRAC_BITS, values
// above 1.0 clamp to 1.0; weight, signed Q8.8. Result channel outcome
// (srp_out_if): result, signed Q1.FRAC_BITS = sign(w) * x^(1/|w|), 0 when x
// or w is zero. Both channels are valid/ready; a request moves on an edge
// with both high.
// Throughput: one request per cycle while the result channel is not stalled.
// NW, the quotient width, is EW + 24 + 8 (EW = bits of FRAC_BITS). The
// pipeline depth is set by the 24 squaring stages of log2, one restoring
// divide stage per quotient bit and 24 root multiply stages.
// The whole pipeline advances together: it moves whenever the output
// register is empty or is being taken, and empty slots travel with the
// data; a stalled receiver holds every stage, with nothing lost or repeated.
// Reset clears all valid bits; the data registers are not reset.
// Depends on srp_pkg, srp_if, srp_log2, srp_exp2 and the macro header.
`timescale 1ns / 1ps
`include "signed_reciprocal_power_macros.svh"
module signed_reciprocal_power import srp_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	srp_in_if.sink      operand,
	srp_out_if.source   outcome
);
	localparam int EW = $clog2(FRAC_BITS+1);
	localparam int LW = EW + LOG_BITS;
	localparam int NW = LW + 8;
	localparam logic [FRAC_BITS:0] ONE_X = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic signed [FRAC_BITS+1:0] ONE_R = (FRAC_BITS+2)'(1) << FRAC_BITS;
	localparam logic signed [FRAC_BITS+1:0] NEG_ONE_R = -ONE_R;

	logic en;
	assign en            = !outcome.valid || outcome.ready;
	assign operand.ready = en;

	// stage 1: clamp, special cases, |w|
	logic [FRAC_BITS:0] x_in;
	logic [W_W-1:0]     w_in;
	srp_side_t          side_in;
	always_comb begin
		x_in         = operand.x_value;
		w_in         = operand.weight;
		side_in.zero = (x_in == '0) || (w_in == '0);
		side_in.one  = x_in >= ONE_X;
		side_in.neg  = w_in[W_W-1];
		side_in.aw   = w_in[W_W-1] ? AW_W'(-$signed({w_in[W_W-1], w_in}))
		                           : {1'b0, w_in};
	end

	logic [FRAC_BITS-1:0] x_s1;
	srp_side_t            side_s1;
	logic                 v_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= x_in[FRAC_BITS-1:0];
			side_s1 <= side_in;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= operand.valid;
	end

	logic                 lv;
	logic [EW-1:0]        le;
	logic [LOG_BITS-1:0]  lf;
	srp_side_t            lside;
	srp_log2 #(.FRAC_BITS(FRAC_BITS)) u_log2 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.v_in(v_s1), .x(x_s1), .side_in(side_s1),
		.v_out(lv), .e(le), .frac(lf), .side_out(lside)
	);

	// restoring divide, one quotient bit per stage; index 0 holds -log2 << 8
	logic [AW_W:0]  rem_s  [0:NW];
	logic [NW-1:0]  nq_s   [0:NW];
	srp_side_t      side_s [0:NW];
	logic           v_s    [0:NW];

	logic [LW-1:0] l_val;
	assign l_val = {le, {LOG_BITS{1'b0}}} - {{EW{1'b0}}, lf};

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= '0;
			nq_s[0]   <= {l_val, 8'b0};
			side_s[0] <= lside;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s[0] <= 1'b0;
		else if (en) v_s[0] <= lv;
	end

	for (genvar i = 0; i < NW; i++) begin : g_div
		logic [AW_W:0] rs;
		logic          ge;
		assign rs = {rem_s[i][AW_W-1:0], nq_s[i][NW-1]};
		assign ge = rs >= {1'b0, side_s[i].aw};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= ge ? rs - {1'b0, side_s[i].aw} : rs;
				nq_s[i+1]   <= {nq_s[i][NW-2:0], ge};
				side_s[i+1] <= side_s[i];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[i+1] <= 1'b0;
			else if (en) v_s[i+1] <= v_s[i];
		end
	end

	srp_exp2 #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_exp2 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.v_in(v_s[NW]), .q(nq_s[NW]), .side_in(side_s[NW]),
		.v_out(outcome.valid), .result(outcome.result)
	);

	`SRP_ASSERT_IMP(a_ready_when_empty, !outcome.valid, operand.ready, "pipeline stalled while output empty")
	`SRP_ASSERT_NXT(a_stall_freezes, !en, $stable(v_s1) && $stable(v_s[NW]) && $stable(lv), "stage moved during stall")
	`SRP_ASSERT_IMP(a_result_range, outcome.valid, $signed(outcome.result) <= ONE_R && $signed(outcome.result) >= NEG_ONE_R, "result beyond unit range")
endmodule

### verif/srp_checker.sv
// Scoreboard for signed_reciprocal_power: predicts each request's result and
// compares it with what leaves the result channel.
// Depends on srp_if (request and result interfaces).
`timescale 1ns / 1ps
module srp_checker (
	input  logic clk,
	input  logic arst_n,
	srp_in_if    req,
	srp_out_if   res,
	output int   fail_count,
	output int   pending
);
	localparam int FB   = 16;
	localparam int LB   = 24;
	localparam logic [63:0] UNITY = 64'd1 << FB;

	logic [63:0] root_q30 [1:LB];
	logic [FB+1:0] power_due [$];

	function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
		logic [63:0] acc;
		logic [63:0] cand;
		acc = '0;
		for (int i = 30; i >= 0; i--) begin
			cand = acc | (64'd1 << i);
			if (cand * cand <= v)
				acc = cand;
		end
		return acc;
	endfunction

	initial begin
		logic [63:0] t;
		t = 64'd1 << 29;
		for (int k = 1; k <= LB; k++) begin
			t = floor_sqrt(t << 30);
			root_q30[k] = t;
		end
	end

	function automatic logic [FB+1:0] signed_power(input logic [FB:0] x,
			input logic [15:0] w);
		logic [63:0] xc, aw, m, frac, nlog, q, n, f, r, mag;
		logic        neg;
		int          p;
		xc  = {47'd0, x};
		neg = w[15];
		aw  = neg ? ((64'h10000 - {48'd0, w}) & 64'h1FFFF) : {48'd0, w};
		if (xc > UNITY)
			xc = UNITY;
		if (xc == 0 || w == 0)
			return '0;
		if (xc == UNITY) begin
			mag = UNITY;
		end else begin
			p = 0;
			for (int k = 0; k < FB; k++)
				if (xc[k])
					p = k;
			m    = xc << (30 - p);
			frac = '0;
			for (int k = 0; k < LB; k++) begin
				m    = (m * m) >> 30;
				frac = frac << 1;
				if (m >= (64'd2 << 30)) begin
					frac = frac | 64'd1;
					m    = m >> 1;
				end
			end
			nlog = (64'(FB - p) << LB) - frac;
			q    = (nlog << 8) / aw;
			n    = q >> LB;
			f    = q & ((64'd1 << LB) - 1);
			r    = 64'd1 << 30;
			for (int k = 1; k <= LB; k++)
				if (f[LB-k])
					r = (r * root_q30[k]) >> 30;
			if (n >= 31) begin
				mag = '0;
			end else begin
				r   = r >> n;
				// round half up to the output fraction width
				r   = (r + (64'd1 << (29 - FB))) >> (30 - FB);
				mag = (r > UNITY) ? UNITY : r;
			end
		end
		return neg ? (FB+2)'(64'd0 - mag) : (FB+2)'(mag);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [FB+1:0] want;
		if (!arst_n) begin
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (req.valid && req.ready)
				power_due.push_back(signed_power(req.x_value, req.weight));
			if (res.valid && res.ready) begin
				if (power_due.size() == 0) begin
					$error("result with no request outstanding: result=%0d", res.result);
					fail_count <= fail_count + 1;
				end else begin
					want = power_due.pop_front();
					if (res.result !== want) begin
						$error("result mismatch: expected %0d, actual %0d",
							$signed(want), $signed(res.result));
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= power_due.size();
		end
	end
endmodule

### verif/tb_top.sv
// Top of the signed_reciprocal_power bench: clock, reset, request stimulus,
// result-side back-pressure and the verdict. Depends on srp_if, srp_checker.
`timescale 1ns / 1ps
module tb_top;
	localparam int FB        = 16;
	localparam int N_RANDOM  = 1630;
	localparam int IDLE_MAX  = 3000;
	localparam int HOLD_LEN  = 400;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   idle_cycles;
	logic hold_req;

	srp_in_if  #(.FRAC_BITS(FB)) req_ch ();
	srp_out_if #(.FRAC_BITS(FB)) res_ch ();

	signed_reciprocal_power #(.FRAC_BITS(FB)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.operand (req_ch),
		.outcome (res_ch)
	);

	srp_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.res        (res_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic int gap_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		if (pick < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// offer one request and hold it until the block takes it
	task automatic send(input logic [FB:0] x, input logic [15:0] w);
		int gap;
		req_ch.valid   <= 1'b1;
		req_ch.x_value <= x;
		req_ch.weight  <= w;
		forever begin
			@(negedge clk);
			if (req_ch.ready)
				break;
			@(posedge clk);
		end
		@(posedge clk);
		gap = gap_len();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// result side: random stalls, stretches of none, one long hold
	initial begin
		int   stall;
		logic held;
		held = 1'b0;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				res_ch.ready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
				res_ch.ready <= 1'b1;
			end else begin
				stall = gap_len();
				if ($urandom_range(0, 3) == 0)
					stall = 0;
				res_ch.ready <= (stall == 0);
				if (stall > 0)
					repeat (stall - 1) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	always @(posedge clk) begin
		if (idle_cycles >= IDLE_MAX) begin
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin
		logic [FB:0] x;
		logic [15:0] w;
		int          kind;
		arst_n         = 1'b0;
		hold_req       = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.x_value = '0;
		req_ch.weight  = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero operands, clamp at and above one, weight extremes, tiny weight
		send(17'd0, 16'h0100);
		send(17'd40000, 16'h0000);
		send(17'd0, 16'h0000);
		send(17'd65536, 16'h0100);
		send(17'd65536, 16'hFF00);
		send(17'h1FFFF, 16'h0200);
		send(17'h1FFFF, 16'hFE00);
		send(17'd1, 16'h0001);
		send(17'd1, 16'hFFFF);
		send(17'd1, 16'h7FFF);
		send(17'd1, 16'h8000);
		send(17'd65535, 16'h7FFF);
		send(17'd65535, 16'h8000);
		send(17'd32768, 16'h0100);
		send(17'd32768, 16'hFF00);
		send(17'd32768, 16'h0080);
		send(17'd100, 16'h0003);
		send(17'd100, 16'hFFFD);
		send(17'd12345, 16'h0555);
		send(17'd50000, 16'hAAAA);

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == 300)
				hold_req = 1'b1;
			kind = $urandom_range(0, 9);
			x = (kind < 7) ? 17'($urandom_range(1, 65535)) : 17'($urandom);
			if (kind == 0)
				w = 16'($urandom_range(0, 15)) ^ {16{$urandom_range(0, 1) == 1}};
			else
				w = 16'($urandom);
			send(x, w);
		end
		req_ch.valid <= 1'b0;

		// the count settles after the last accepting edge
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (120) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end
endmodule
